FILE: rtl/core/mffdm_pkg.sv
// Package for the maze flood-fill distance map.
// Holds the transaction payload types, operation codes and controller/datapath interface structs.
// Depends on nothing.
package mffdm_pkg;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_COMPUTE = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    localparam logic RK_READ = 1'b0;
    localparam logic RK_DONE = 1'b1;

    localparam logic [7:0] UNREACHED = 8'd255;
    localparam logic [7:0] DIST_MAX  = 8'd254;
    localparam logic [7:0] DIST_ZERO = 8'd0;

    typedef struct packed {
        logic [1:0] operation;
        logic [3:0] cell_x;
        logic [3:0] cell_y;
        logic       wall_right;
        logic       wall_left;
        logic       wall_front;
        logic       wall_back;
        logic       is_goal;
    } item_t;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] distance;
    } result_t;

    typedef struct packed {
        logic clr_wr;
        logic load_wr;
        logic rd_issue;
        logic cell_rd;
        logic init_wr;
        logic center_rd;
        logic dir_step;
        logic nbr_rd;
        logic nbr_wr;
        logic cnt_step;
        logic scan_start;
        logic level_step;
        logic map_set;
        logic out_read;
        logic out_done;
    } cmd_t;

    typedef struct packed {
        logic last_cell;
        logic center_hit;
        logic nbr_open;
        logic nbr_unreached;
        logic last_dir;
        logic changed;
        logic out_free;
    } status_t;

endpackage

FILE: rtl/core/mffdm_ctrl.sv
// Controller state machine for the maze flood-fill distance map.
// Sequences the clearing sweep, loads, reads and the flood passes; uses mffdm_pkg.
module mffdm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic [1:0]          operation,
    input  mffdm_pkg::status_t  status,
    output logic                item_stall,
    output mffdm_pkg::cmd_t     cmd
);
    import mffdm_pkg::*;

    typedef enum logic [10:0] {
        S_CLEAR   = 11'b00000000001,
        S_IDLE    = 11'b00000000010,
        S_RDATA   = 11'b00000000100,
        S_INIT_RD = 11'b00000001000,
        S_INIT_WR = 11'b00000010000,
        S_C_RD    = 11'b00000100000,
        S_C_CHK   = 11'b00001000000,
        S_N_SEL   = 11'b00010000000,
        S_N_CHK   = 11'b00100000000,
        S_ADV     = 11'b01000000000,
        S_DONE    = 11'b10000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_stall = 1'b1;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr   = 1'b1;
                cmd.cnt_step = 1'b1;
                if (status.last_cell)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    unique case (operation)
                        OP_LOAD:
                        begin
                            cmd.load_wr = 1'b1;
                        end
                        OP_READ:
                        begin
                            cmd.rd_issue = 1'b1;
                            state_next   = S_RDATA;
                        end
                        OP_COMPUTE:
                        begin
                            state_next = S_INIT_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RDATA:
            begin
                if (status.out_free)
                begin
                    cmd.out_read = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_INIT_RD:
            begin
                cmd.cell_rd = 1'b1;
                state_next  = S_INIT_WR;
            end
            S_INIT_WR:
            begin
                cmd.init_wr  = 1'b1;
                cmd.cnt_step = 1'b1;
                if (status.last_cell)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_C_RD;
                end
                else
                begin
                    state_next = S_INIT_RD;
                end
            end
            S_C_RD:
            begin
                cmd.center_rd = 1'b1;
                state_next    = S_C_CHK;
            end
            S_C_CHK:
            begin
                state_next = status.center_hit ? S_N_SEL : S_ADV;
            end
            S_N_SEL:
            begin
                if (status.nbr_open)
                begin
                    cmd.nbr_rd = 1'b1;
                    state_next = S_N_CHK;
                end
                else if (status.last_dir)
                begin
                    state_next = S_ADV;
                end
                else
                begin
                    cmd.dir_step = 1'b1;
                end
            end
            S_N_CHK:
            begin
                cmd.nbr_wr = status.nbr_unreached;
                if (status.last_dir)
                begin
                    state_next = S_ADV;
                end
                else
                begin
                    cmd.dir_step = 1'b1;
                    state_next   = S_N_SEL;
                end
            end
            S_ADV:
            begin
                cmd.cnt_step = 1'b1;
                if (!status.last_cell)
                begin
                    state_next = S_C_RD;
                end
                else if (status.changed)
                begin
                    cmd.level_step = 1'b1;
                    state_next     = S_C_RD;
                end
                else
                begin
                    cmd.map_set = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_done = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

FILE: rtl/core/mffdm_datapath.sv
// Datapath for the maze flood-fill distance map.
// Holds the wall/goal and distance memories, scan counters, level and result register;
// driven by mffdm_ctrl through mffdm_pkg command and status structs.
module mffdm_datapath #(
    parameter int GRID_SIDE = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mffdm_pkg::item_t    item,
    input  mffdm_pkg::cmd_t     cmd,
    input  logic                result_stall,
    output mffdm_pkg::status_t  status,
    output logic                result_valid,
    output mffdm_pkg::result_t  result
);
    import mffdm_pkg::*;

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(GRID_SIDE);
    localparam logic [CW-1:0] X_LAST = CW'(GRID_SIDE - 1);
    localparam logic [CW-1:0] X_ZERO = '0;
    localparam logic [CW-1:0] X_ONE  = CW'(1);

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] cx,
                                                 input logic [CW-1:0] cy);
        return AW'(int'(cx) * GRID_SIDE + int'(cy));
    endfunction

    logic [4:0]    cell_mem [CELLS];
    logic [7:0]    dist_mem [CELLS];
    logic [4:0]    cell_rdata;
    logic [7:0]    dist_rdata;

    logic [CW-1:0] x_reg, x_next;
    logic [CW-1:0] y_reg, y_next;
    logic [1:0]    dir_reg;
    logic [7:0]    level_reg;
    logic          changed_reg;
    logic          map_valid_reg;
    logic          rd_inside_reg;
    logic          out_valid_reg;
    result_t       out_data_reg;

    logic          in_inside;
    logic [AW-1:0] in_addr;
    logic [AW-1:0] ctr_addr;
    logic [CW-1:0] nx, ny;
    logic          nbr_exists;
    logic [AW-1:0] nbr_addr;
    logic [7:0]    next_dist;
    logic          out_free;

    assign in_inside = (int'(item.cell_x) < GRID_SIDE) && (int'(item.cell_y) < GRID_SIDE);
    assign in_addr   = AW'(int'(item.cell_x) * GRID_SIDE + int'(item.cell_y));
    assign ctr_addr  = cell_addr(x_reg, y_reg);
    assign next_dist = (level_reg < DIST_MAX) ? level_reg + 8'd1 : DIST_MAX;
    assign out_free  = !out_valid_reg || !result_stall;

    always_comb
    begin
        nx         = x_reg;
        ny         = y_reg;
        nbr_exists = 1'b0;
        unique case (dir_reg)
            2'd0:
            begin
                nx         = x_reg + X_ONE;
                nbr_exists = (x_reg != X_LAST);
            end
            2'd1:
            begin
                nx         = x_reg - X_ONE;
                nbr_exists = (x_reg != X_ZERO);
            end
            2'd2:
            begin
                ny         = y_reg + X_ONE;
                nbr_exists = (y_reg != X_LAST);
            end
            2'd3:
            begin
                ny         = y_reg - X_ONE;
                nbr_exists = (y_reg != X_ZERO);
            end
            default:
            begin
                nbr_exists = 1'b0;
            end
        endcase
    end

    assign nbr_addr = cell_addr(nx, ny);

    always_comb
    begin
        status.last_cell     = (x_reg == X_LAST) && (y_reg == X_LAST);
        status.center_hit    = (dist_rdata == level_reg);
        status.nbr_open      = nbr_exists && !cell_rdata[dir_reg];
        status.nbr_unreached = (dist_rdata == UNREACHED);
        status.last_dir      = (dir_reg == 2'd3);
        status.changed       = changed_reg;
        status.out_free      = out_free;
    end

    always_comb
    begin
        y_next = y_reg;
        x_next = x_reg;
        if (cmd.cnt_step)
        begin
            if (y_reg == X_LAST)
            begin
                y_next = X_ZERO;
                x_next = (x_reg == X_LAST) ? X_ZERO : x_reg + X_ONE;
            end
            else
            begin
                y_next = y_reg + X_ONE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
        begin
            cell_mem[ctr_addr] <= '0;
        end
        else if (cmd.load_wr && in_inside)
        begin
            cell_mem[in_addr] <= {item.is_goal, item.wall_back, item.wall_front,
                                  item.wall_left, item.wall_right};
        end
        if (cmd.cell_rd || cmd.center_rd)
        begin
            cell_rdata <= cell_mem[ctr_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init_wr)
        begin
            dist_mem[ctr_addr] <= cell_rdata[4] ? DIST_ZERO : UNREACHED;
        end
        else if (cmd.nbr_wr)
        begin
            dist_mem[nbr_addr] <= next_dist;
        end
        if (cmd.rd_issue)
        begin
            dist_rdata <= dist_mem[in_addr];
        end
        else if (cmd.center_rd)
        begin
            dist_rdata <= dist_mem[ctr_addr];
        end
        else if (cmd.nbr_rd)
        begin
            dist_rdata <= dist_mem[nbr_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
        begin
            rd_inside_reg <= in_inside;
        end
        if (cmd.out_read)
        begin
            out_data_reg.result_kind <= RK_READ;
            out_data_reg.distance    <= (rd_inside_reg && map_valid_reg) ? dist_rdata
                                                                         : UNREACHED;
        end
        else if (cmd.out_done)
        begin
            out_data_reg.result_kind <= RK_DONE;
            out_data_reg.distance    <= DIST_ZERO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg         <= '0;
            y_reg         <= '0;
            dir_reg       <= '0;
            level_reg     <= '0;
            changed_reg   <= 1'b0;
            map_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            if (cmd.center_rd)
            begin
                dir_reg <= '0;
            end
            else if (cmd.dir_step)
            begin
                dir_reg <= dir_reg + 2'd1;
            end
            if (cmd.scan_start)
            begin
                level_reg <= DIST_ZERO;
            end
            else if (cmd.level_step)
            begin
                level_reg <= next_dist;
            end
            if (cmd.scan_start || cmd.level_step)
            begin
                changed_reg <= 1'b0;
            end
            else if (cmd.nbr_wr)
            begin
                changed_reg <= 1'b1;
            end
            if (cmd.map_set)
            begin
                map_valid_reg <= 1'b1;
            end
            if (cmd.out_read || cmd.out_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

`ifndef SYNTH
    a_nbr_wr_unreached: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.nbr_wr |-> dist_rdata == UNREACHED)
        else $error("neighbor written although already reached");
    a_nbr_wr_open: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.nbr_wr |-> (nbr_exists && !cell_rdata[dir_reg]))
        else $error("neighbor written through a wall or past the grid edge");
    a_nbr_wr_changed: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.nbr_wr && !cmd.level_step && !cmd.scan_start) |=> changed_reg)
        else $error("pass change flag missed a neighbor write");
    a_level_sat: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= DIST_MAX)
        else $error("flood level beyond saturation");
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_read || cmd.out_done) |-> out_free)
        else $error("result register overwritten while still held");
`endif

endmodule

FILE: rtl/core/maze_flood_fill_distance_map.sv
// Top level of the maze flood-fill distance map.
// Joins the controller (mffdm_ctrl) and the datapath (mffdm_datapath); uses mffdm_pkg.
//
// Usage: items arrive on the item channel (item_valid, item_stall, item) and results
// leave on the result channel (result_valid, result_stall, result). A transaction
// completes on a rising edge with valid high and stall low.
// A load transaction writes one cell's walls and goal mark and gives no result. A read
// transaction returns the cell's distance, or 255 before the first compute or for a
// cell outside the grid.
// A compute transaction first presets the map, then makes one pass per distance level,
// repeated at the saturated level while it still changes, plus one final pass; each
// pass scans every cell and, for every cell at that level, tries its four directions
// in turn and reads each open neighbour through the single read port of the distance
// memory. It ends with a result of kind 1 and distance 0.
// After reset the wall and goal memory is cleared, one cell per cycle, over all
// GRID_SIDE*GRID_SIDE cells; item_stall stays high meanwhile.
// Items are taken one at a time. A finished result sits in an output register; while
// the receiver stalls, loads are still taken, and a read or compute waits for the
// register to drain before it delivers.
module maze_flood_fill_distance_map #(
    parameter int GRID_SIDE = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  mffdm_pkg::item_t    item,
    output logic                result_valid,
    input  logic                result_stall,
    output mffdm_pkg::result_t  result
);
    import mffdm_pkg::*;

    cmd_t    cmd;
    status_t status;

    mffdm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .operation  (item.operation),
        .status     (status),
        .item_stall (item_stall),
        .cmd        (cmd)
    );

    mffdm_datapath #(
        .GRID_SIDE (GRID_SIDE)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .result_stall (result_stall),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for maze_flood_fill_distance_map: drives load, compute, read and
// unused-opcode transactions and checks every result against a flood-fill predictor in a
// scoreboard class. Depends on mffdm_pkg and the RTL top level.
module tb;
    import mffdm_pkg::*;

    localparam int SIDE = 16;
    localparam int CELLS = SIDE * SIDE;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    class dist_scoreboard;
        logic [3:0] wall_mem [CELLS];
        logic       goal_mem [CELLS];
        logic [7:0] dist_mem [CELLS];
        result_t    due_q [$];
        int         errors;

        function new();
            int k;
            for (k = 0; k < CELLS; k++)
            begin
                wall_mem[k] = '0;
                goal_mem[k] = 1'b0;
                dist_mem[k] = UNREACHED;
            end
            errors = 0;
        endfunction

        function bit claim_cell(int x, int y, logic [7:0] value);
            int k;
            k = x * SIDE + y;
            if (dist_mem[k] != UNREACHED)
                return 1'b0;
            dist_mem[k] = value;
            return 1'b1;
        endfunction

        function void flood_distances();
            int level;
            int k;
            int x;
            int y;
            bit changed;
            logic [7:0] nxt;
            logic [3:0] w;
            for (k = 0; k < CELLS; k++)
                dist_mem[k] = goal_mem[k] ? DIST_ZERO : UNREACHED;
            level = 0;
            while (1)
            begin
                changed = 1'b0;
                nxt = 8'((level < DIST_MAX) ? level + 1 : DIST_MAX);
                for (x = 0; x < SIDE; x++)
                begin
                    for (y = 0; y < SIDE; y++)
                    begin
                        k = x * SIDE + y;
                        if (dist_mem[k] != level)
                            continue;
                        w = wall_mem[k];
                        if (x + 1 < SIDE && !w[0] && claim_cell(x + 1, y, nxt))
                            changed = 1'b1;
                        if (x > 0 && !w[1] && claim_cell(x - 1, y, nxt))
                            changed = 1'b1;
                        if (y + 1 < SIDE && !w[2] && claim_cell(x, y + 1, nxt))
                            changed = 1'b1;
                        if (y > 0 && !w[3] && claim_cell(x, y - 1, nxt))
                            changed = 1'b1;
                    end
                end
                if (!changed)
                    break;
                if (level < DIST_MAX)
                    level++;
            end
        endfunction

        function void note_item(item_t it);
            int k;
            result_t r;
            k = it.cell_x * SIDE + it.cell_y;
            case (it.operation)
                OP_LOAD:
                begin
                    wall_mem[k] = {it.wall_back, it.wall_front, it.wall_left, it.wall_right};
                    goal_mem[k] = it.is_goal;
                end
                OP_COMPUTE:
                begin
                    flood_distances();
                    r.result_kind = RK_DONE;
                    r.distance = DIST_ZERO;
                    due_q.push_back(r);
                end
                OP_READ:
                begin
                    r.result_kind = RK_READ;
                    r.distance = dist_mem[k];
                    due_q.push_back(r);
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (due_q.size() == 0)
            begin
                $error("unexpected result: result_kind %0d distance %0d",
                       got.result_kind, got.distance);
                errors++;
                return;
            end
            want = due_q.pop_front();
            if (got.result_kind !== want.result_kind)
            begin
                $error("result_kind: expected %0d, actual %0d",
                       want.result_kind, got.result_kind);
                errors++;
            end
            if (got.distance !== want.distance)
            begin
                $error("distance: expected %0d, actual %0d", want.distance, got.distance);
                errors++;
            end
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    dist_scoreboard sb;
    int items_sent;
    int stall_left;
    bit long_hold_go;
    bit long_hold_done;

    maze_flood_fill_distance_map #(
        .GRID_SIDE(SIDE)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic int input_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 100);
    endfunction

    function automatic int stall_run_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(0, 2);
        if (r < 95)
            return $urandom_range(3, 20);
        return $urandom_range(30, 120);
    endfunction

    function automatic int open_run_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(100, 300);
        return $urandom_range(0, 40);
    endfunction

    function automatic item_t make_item(logic [1:0] op, int x, int y, logic [3:0] w, logic g);
        item_t it;
        it.operation = op;
        it.cell_x = x[3:0];
        it.cell_y = y[3:0];
        it.wall_right = w[0];
        it.wall_left = w[1];
        it.wall_front = w[2];
        it.wall_back = w[3];
        it.is_goal = g;
        return it;
    endfunction

    function automatic item_t rand_item(logic [1:0] op);
        item_t it;
        it.operation = op;
        it.cell_x = 4'($urandom_range(0, 15));
        it.cell_y = 4'($urandom_range(0, 15));
        it.wall_right = ($urandom_range(0, 9) < 3);
        it.wall_left = ($urandom_range(0, 9) < 3);
        it.wall_front = ($urandom_range(0, 9) < 3);
        it.wall_back = ($urandom_range(0, 9) < 3);
        it.is_goal = ($urandom_range(0, 99) < 6);
        return it;
    endfunction

    function automatic int snake_pos(int x, int y);
        return (x % 2 == 0) ? x * SIDE + y : x * SIDE + (SIDE - 1 - y);
    endfunction

    function automatic bit path_link(int a, int b);
        return (a - b == 1) || (b - a == 1);
    endfunction

    task automatic send_item(item_t it);
        int gap;
        item_valid <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (item_stall);
        sb.note_item(it);
        if (it.operation != OP_UNUSED)
            items_sent++;
        gap = input_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        send_item(make_item(OP_READ, 0, 0, 4'b0000, 1'b0));
        send_item(make_item(OP_READ, 15, 15, 4'b1111, 1'b1));
        send_item(make_item(OP_UNUSED, 15, 15, 4'b1111, 1'b1));
        send_item(make_item(OP_COMPUTE, 0, 0, 4'b0000, 1'b0));
        send_item(make_item(OP_READ, 9, 6, 4'b0000, 1'b0));
        send_item(make_item(OP_LOAD, 0, 0, 4'b0000, 1'b1));
        send_item(make_item(OP_LOAD, 1, 0, 4'b0010, 1'b0));
        send_item(make_item(OP_LOAD, 0, 1, 4'b1111, 1'b0));
        send_item(make_item(OP_LOAD, 15, 15, 4'b1111, 1'b1));
        send_item(make_item(OP_LOAD, 15, 0, 4'b0000, 1'b0));
        send_item(make_item(OP_UNUSED, 0, 0, 4'b0000, 1'b0));
        send_item(make_item(OP_COMPUTE, 15, 15, 4'b1111, 1'b1));
        send_item(make_item(OP_READ, 1, 0, 4'b0000, 1'b0));
        send_item(make_item(OP_READ, 0, 1, 4'b0000, 1'b0));
        send_item(make_item(OP_READ, 0, 2, 4'b0000, 1'b0));
        send_item(make_item(OP_READ, 15, 15, 4'b0000, 1'b0));
        send_item(make_item(OP_READ, 14, 15, 4'b0000, 1'b0));
        send_item(make_item(OP_READ, 15, 0, 4'b0000, 1'b0));
        send_item(make_item(OP_READ, 0, 15, 4'b0000, 1'b0));
    endtask

    task automatic run_maze_episode();
        int n;
        int i;
        int r;
        n = $urandom_range(10, 50);
        for (i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                send_item(rand_item(OP_UNUSED));
            else if (r < 14)
                send_item(rand_item(OP_READ));
            else
                send_item(rand_item(OP_LOAD));
        end
        send_item(rand_item(OP_COMPUTE));
        n = $urandom_range(10, 30);
        for (i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                send_item(rand_item(OP_UNUSED));
            else
                send_item(rand_item(OP_READ));
        end
    endtask

    // A single winding corridor through every cell drives the distances into saturation.
    task automatic run_snake_episode();
        int x;
        int y;
        int p;
        int i;
        logic [3:0] w;
        for (x = 0; x < SIDE; x++)
        begin
            for (y = 0; y < SIDE; y++)
            begin
                p = snake_pos(x, y);
                w = 4'b1111;
                if (x + 1 < SIDE && path_link(snake_pos(x + 1, y), p))
                    w[0] = 1'b0;
                if (x > 0 && path_link(snake_pos(x - 1, y), p))
                    w[1] = 1'b0;
                if (y + 1 < SIDE && path_link(snake_pos(x, y + 1), p))
                    w[2] = 1'b0;
                if (y > 0 && path_link(snake_pos(x, y - 1), p))
                    w[3] = 1'b0;
                send_item(make_item(OP_LOAD, x, y, w, p == 0));
            end
        end
        send_item(rand_item(OP_COMPUTE));
        send_item(make_item(OP_READ, 15, 0, 4'b0000, 1'b0));
        send_item(make_item(OP_READ, 15, 1, 4'b0000, 1'b0));
        send_item(make_item(OP_READ, 15, 2, 4'b0000, 1'b0));
        send_item(make_item(OP_READ, 0, 0, 4'b0000, 1'b0));
        send_item(make_item(OP_READ, 0, 1, 4'b0000, 1'b0));
        for (i = 0; i < 12; i++)
            send_item(rand_item(OP_READ));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (long_hold_go && !long_hold_done)
        begin
            long_hold_done <= 1'b1;
            result_stall <= 1'b1;
            stall_left <= 400;
        end
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if (result_stall)
        begin
            result_stall <= 1'b0;
            stall_left <= open_run_len();
        end
        else
        begin
            result_stall <= 1'b1;
            stall_left <= stall_run_len();
        end
    end

    initial
    begin
        int episode;
        sb = new();
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_stall = 1'b0;
        stall_left = 0;
        long_hold_go = 1'b0;
        long_hold_done = 1'b0;
        items_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        drain_results();
        episode = 0;
        while (items_sent < 580)
        begin
            if (episode == 1)
                long_hold_go <= 1'b1;
            run_maze_episode();
            if (episode % 2 == 0)
                drain_results();
            episode++;
        end
        run_snake_episode();
        drain_results();
        repeat (600) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #(64'd600_000_000);
        $display("CHECK FAILED");
        $finish;
    end
endmodule

FILE: maze_flood_fill_distance_map.f
rtl/core/mffdm_pkg.sv
rtl/core/mffdm_ctrl.sv
rtl/core/mffdm_datapath.sv
rtl/core/maze_flood_fill_distance_map.sv
verif/tb.sv
